// ===== design/srle_pkg.sv =====
// Shared types and constants for the scanline run-length encoder.
package srle_pkg;

   localparam logic [7:0] RUN_LIMIT = 8'd255;
   localparam logic [3:0] HDR_LAST_IDX = 4'd9;
   localparam logic [7:0] BPP_COLOR = 8'd24;
   localparam logic [7:0] BPP_GRAY = 8'd8;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
      logic        color;
   } csr_type;

   typedef struct packed {
      logic        hdr;
      logic [15:0] width;
      logic [15:0] height;
      logic        color;
      logic        a_valid;
      logic [7:0]  a_count;
      logic [23:0] a_pixel;
      logic        b_valid;
      logic [7:0]  b_count;
      logic [23:0] b_pixel;
      logic        frame_end;
   } job_type;

endpackage

// ===== design/scanline_run_length_encoder.sv =====
// Top level of the scanline run-length encoder with its register port.
//
// Pixels enter in raster order through push/full and leave as a byte stream
// through pop/empty, one byte per cycle while pop is held, from a single
// output register. A pixel causes as many bytes as its job holds: none when
// it only extends a run, two or four for each run it closes (gray or color),
// and ten more for the frame header on the first pixel of a frame. The front
// end takes a pixel every cycle while the job queue (QUEUE_DEPTH entries) has
// room; after the serializer has gone idle, a job is first loaded into its
// job register and only then is its first byte registered. Registers:
// frame_width at 0x0, frame_height at 0x4, color_mode at 0x8; write them
// only while the encoder is idle.
module scanline_run_length_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        push,
   output logic        full,
   input  logic [23:0] req_pixel_value,
   input  logic        pop,
   output logic        empty,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_for_item,
   output logic        rsp_frame_done
);
   import srle_pkg::*;

   csr_type     csr_ff;
   logic        csr_write;
   logic [1:0]  reg_idx;
   logic        accept;
   logic        job_push;
   job_type     job;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   job_type     q_data;

   always_comb begin
      pready = 1'b1;
      reg_idx = paddr[3:2];
      csr_write = psel && penable && pwrite;
      unique case (reg_idx)
         REG_WIDTH: prdata = {16'd0, csr_ff.width};
         REG_HEIGHT: prdata = {16'd0, csr_ff.height};
         REG_MODE: prdata = {31'd0, csr_ff.color};
         default: prdata = 32'd0;
      endcase
      full = q_full;
      accept = push && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.width <= 16'd1;
         csr_ff.height <= 16'd1;
         csr_ff.color <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_WIDTH: csr_ff.width <= pwdata[15:0];
            REG_HEIGHT: csr_ff.height <= pwdata[15:0];
            REG_MODE: csr_ff.color <= pwdata[0];
            default: csr_ff.color <= csr_ff.color;
         endcase
      end
   end

   srle_front u_front (
      .clock(clock),
      .reset(reset),
      .csr(csr_ff),
      .accept(accept),
      .pixel_value(req_pixel_value),
      .job_push(job_push),
      .job(job)
   );

   srle_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_en(job_push),
      .push_data(job),
      .q_full(q_full),
      .pop_en(q_pop),
      .pop_data(q_data),
      .q_empty(q_empty)
   );

   srle_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .pop(pop),
      .empty(empty),
      .out_byte(rsp_out_byte),
      .last_for_item(rsp_last_for_item),
      .frame_done(rsp_frame_done)
   );

endmodule

// ===== design/srle_front.sv =====
// Front end: accepts pixels, tracks runs and position, and emits output jobs.
module srle_front (
   input  logic             clock,
   input  logic             reset,
   input  srle_pkg::csr_type csr,
   input  logic             accept,
   input  logic [23:0]      pixel_value,
   output logic             job_push,
   output srle_pkg::job_type job
);
   import srle_pkg::*;

   logic [23:0] run_pixel_ff, run_pixel_in;
   logic [7:0]  run_count_ff, run_count_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;
   logic        header_sent_ff, header_sent_in;

   logic [23:0] pix;
   logic        flush_a;
   logic [7:0]  count_kept;
   logic [7:0]  count_new;
   logic [23:0] pixel_new;
   logic        row_wrap;
   logic        frame_end;
   logic        close_b;

   always_comb begin
      pix = csr.color ? pixel_value : {16'd0, pixel_value[7:0]};
      flush_a = (run_count_ff != 8'd0) && (run_pixel_ff != pix);
      count_kept = flush_a ? 8'd0 : run_count_ff;
      pixel_new = (count_kept == 8'd0) ? pix : run_pixel_ff;
      count_new = count_kept + 8'd1;
      row_wrap = ({1'b0, column_ff} + 17'd1) >= {1'b0, csr.width};
      frame_end = row_wrap && (({1'b0, row_ff} + 17'd1) >= {1'b0, csr.height});
      close_b = (count_new == RUN_LIMIT) || row_wrap;

      run_pixel_in = pixel_new;
      run_count_in = close_b ? 8'd0 : count_new;
      column_in = row_wrap ? 16'd0 : column_ff + 16'd1;
      if (!row_wrap) begin
         row_in = row_ff;
      end else if (frame_end) begin
         row_in = 16'd0;
      end else begin
         row_in = row_ff + 16'd1;
      end
      header_sent_in = !frame_end;

      job.hdr = !header_sent_ff;
      job.width = csr.width;
      job.height = csr.height;
      job.color = csr.color;
      job.a_valid = flush_a;
      job.a_count = run_count_ff;
      job.a_pixel = run_pixel_ff;
      job.b_valid = close_b;
      job.b_count = count_new;
      job.b_pixel = pixel_new;
      job.frame_end = frame_end;
      job_push = accept && (!header_sent_ff || flush_a || close_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pixel_ff <= 24'd0;
         run_count_ff <= 8'd0;
         column_ff <= 16'd0;
         row_ff <= 16'd0;
         header_sent_ff <= 1'b0;
      end else if (accept) begin
         run_pixel_ff <= run_pixel_in;
         run_count_ff <= run_count_in;
         column_ff <= column_in;
         row_ff <= row_in;
         header_sent_ff <= header_sent_in;
      end
   end

endmodule

// ===== design/srle_queue.sv =====
// Short job queue between the front and back ends.
module srle_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  srle_pkg::job_type push_data,
   output logic             q_full,
   input  logic             pop_en,
   output srle_pkg::job_type pop_data,
   output logic             q_empty
);
   import srle_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   job_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      q_full = (count_ff == FULL_COUNT);
      q_empty = (count_ff == '0);
      do_push = push_en && !q_full;
      do_pop = pop_en && !q_empty;
      wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
      pop_data = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/srle_back.sv =====
// Back end: serializes jobs into header and run-record bytes.
module srle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  srle_pkg::job_type q_data,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       out_byte,
   output logic             last_for_item,
   output logic             frame_done
);
   import srle_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_HDR, S_RUN_A, S_RUN_B} state_type;

   state_type   state_ff, state_in, first_state;
   job_type     job_ff;
   logic [3:0]  idx_ff;
   logic        out_valid_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        done_ff;

   logic        emit_ok;
   logic        advance;
   logic        seg_end;
   logic        is_last;
   logic        load;
   logic [7:0]  cur_byte;
   logic [7:0]  run_count;
   logic [23:0] run_pixel;
   logic [3:0]  run_last_idx;
   state_type   after_seg;

   always_comb begin
      emit_ok = !out_valid_ff || pop;
      advance = (state_ff != S_IDLE) && emit_ok;

      run_count = (state_ff == S_RUN_A) ? job_ff.a_count : job_ff.b_count;
      run_pixel = (state_ff == S_RUN_A) ? job_ff.a_pixel : job_ff.b_pixel;
      run_last_idx = job_ff.color ? 4'd3 : 4'd1;

      cur_byte = 8'd0;
      seg_end = 1'b0;
      after_seg = S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cur_byte = 8'd0;
         end
         S_HDR: begin
            unique case (idx_ff)
               4'd0: cur_byte = job_ff.width[15:8];
               4'd1: cur_byte = job_ff.width[7:0];
               4'd2: cur_byte = job_ff.height[15:8];
               4'd3: cur_byte = job_ff.height[7:0];
               4'd9: cur_byte = job_ff.color ? BPP_COLOR : BPP_GRAY;
               default: cur_byte = 8'd0;
            endcase
            seg_end = (idx_ff == HDR_LAST_IDX);
            if (job_ff.a_valid) begin
               after_seg = S_RUN_A;
            end else if (job_ff.b_valid) begin
               after_seg = S_RUN_B;
            end
         end
         S_RUN_A, S_RUN_B: begin
            if (idx_ff == 4'd0) begin
               cur_byte = run_count;
            end else if (!job_ff.color) begin
               cur_byte = run_pixel[7:0];
            end else begin
               unique case (idx_ff[1:0])
                  2'd1: cur_byte = run_pixel[23:16];
                  2'd2: cur_byte = run_pixel[15:8];
                  default: cur_byte = run_pixel[7:0];
               endcase
            end
            seg_end = (idx_ff == run_last_idx);
            if (state_ff == S_RUN_A && job_ff.b_valid) begin
               after_seg = S_RUN_B;
            end
         end
         default: begin
            cur_byte = 8'd0;
         end
      endcase
      is_last = seg_end && (after_seg == S_IDLE);

      load = !q_empty && ((state_ff == S_IDLE) || (advance && is_last));
      q_pop = load;

      if (q_data.hdr) begin
         first_state = S_HDR;
      end else if (q_data.a_valid) begin
         first_state = S_RUN_A;
      end else begin
         first_state = S_RUN_B;
      end

      if (load) begin
         state_in = first_state;
      end else if (advance && seg_end) begin
         state_in = after_seg;
      end else begin
         state_in = state_ff;
      end

      empty = !out_valid_ff;
      out_byte = byte_ff;
      last_for_item = last_ff;
      frame_done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load || (advance && seg_end)) begin
            idx_ff <= 4'd0;
         end else if (advance) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         job_ff <= q_data;
      end
      if (advance) begin
         byte_ff <= cur_byte;
         last_ff <= is_last;
         done_ff <= is_last && job_ff.frame_end;
      end
   end

endmodule

// ===== sim/scanline_run_length_encoder_tb.sv =====
// Self-checking testbench for the scanline run-length encoder against a predictor.
`timescale 1ns / 1ps

module scanline_run_length_encoder_tb;
   import srle_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PIXELS = 400;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } enc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        push = 1'b0;
   logic        full;
   logic [23:0] req_pixel_value = '0;
   logic        pop = 1'b0;
   logic        empty;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_for_item;
   logic        rsp_frame_done;

   logic [23:0]  pixel_queue[$];
   enc_byte_type expected_bytes[$];

   logic [15:0] cfg_width = 16'd1;
   logic [15:0] cfg_height = 16'd1;
   logic        cfg_color = 1'b0;
   logic [23:0] run_px = '0;
   int          run_len = 0;
   logic [15:0] col_idx = '0;
   logic [15:0] row_idx = '0;
   logic        hdr_sent = 1'b0;

   bit pixel_taken = 1'b0;
   bit byte_taken = 1'b0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int pixels_sent = 0;
   int bytes_checked = 0;
   int frames_closed = 0;
   int reg_writes = 0;

   scanline_run_length_encoder uut (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .push(push),
      .full(full),
      .req_pixel_value(req_pixel_value),
      .pop(pop),
      .empty(empty),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_for_item(rsp_last_for_item),
      .rsp_frame_done(rsp_frame_done)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int draw_gap(bit idle_on);
      return idle_on ? int'($urandom_range(0, 4)) : 0;
   endfunction

   function automatic void emit(logic [7:0] value);
      enc_byte_type rec;
      rec.data = value;
      rec.last = 1'b0;
      rec.done = 1'b0;
      expected_bytes.push_back(rec);
   endfunction

   function automatic void close_run();
      emit(8'(run_len));
      if (cfg_color) begin
         emit(run_px[23:16]);
         emit(run_px[15:8]);
      end
      emit(run_px[7:0]);
      run_len = 0;
   endfunction

   function automatic void encode_pixel(logic [23:0] raw);
      logic [23:0]  px;
      logic         row_wrap;
      logic         frame_end;
      int           first;
      enc_byte_type rec;
      first = expected_bytes.size();
      px = cfg_color ? raw : {16'h0000, raw[7:0]};
      frame_end = 1'b0;
      if (!hdr_sent) begin
         emit(cfg_width[15:8]);
         emit(cfg_width[7:0]);
         emit(cfg_height[15:8]);
         emit(cfg_height[7:0]);
         repeat (5) emit(8'h00);
         emit(cfg_color ? BPP_COLOR : BPP_GRAY);
         hdr_sent = 1'b1;
      end
      if (run_len != 0 && run_px != px) close_run();
      if (run_len == 0) run_px = px;
      run_len++;
      row_wrap = (int'(col_idx) + 1) >= int'(cfg_width);
      if (run_len >= int'(RUN_LIMIT) || row_wrap) close_run();
      if (row_wrap) begin
         col_idx = '0;
         if ((int'(row_idx) + 1) >= int'(cfg_height)) begin
            row_idx = '0;
            hdr_sent = 1'b0;
            frame_end = 1'b1;
         end else begin
            row_idx = row_idx + 16'd1;
         end
      end else begin
         col_idx = col_idx + 16'd1;
      end
      if (expected_bytes.size() > first) begin
         rec = expected_bytes.pop_back();
         rec.last = 1'b1;
         rec.done = frame_end;
         expected_bytes.push_back(rec);
      end
   endfunction

   function automatic logic [23:0] next_pixel(logic [23:0] prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return prev;
         5: return prev ^ (24'h1 << $urandom_range(8, 23));
         6: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 30) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_WIDTH: cfg_width = value[15:0];
         REG_HEIGHT: cfg_height = value[15:0];
         REG_MODE: cfg_color = value[0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      case (idx)
         REG_WIDTH: want = {16'd0, cfg_width};
         REG_HEIGHT: want = {16'd0, cfg_height};
         REG_MODE: want = {31'd0, cfg_color};
         default: want = 32'd0;
      endcase
      if (prdata !== want)
         report_mismatch($sformatf("register %0d reads %08h, want %08h", idx, prdata, want));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_frame(logic [15:0] w, logic [15:0] h, logic color);
      write_reg(REG_WIDTH, {16'($urandom()), w});
      write_reg(REG_HEIGHT, {16'($urandom()), h});
      write_reg(REG_MODE, {31'($urandom()), color});
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || push || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_proc
      logic offer;
      offer = push;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (push && pixel_taken) offer = 1'b0;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pixel_queue.size() != 0) begin
               req_pixel_value <= pixel_queue.pop_front();
               offer = 1'b1;
               send_gap = draw_gap(send_idle_on);
            end
         end
      end
      push <= offer;
   end

   always @(negedge clock) begin : recv_proc
      logic take;
      take = pop;
      if (reset) begin
         take = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         take = 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
         take = 1'b0;
      end else if (pop) begin
         if (byte_taken) begin
            recv_gap = draw_gap(recv_idle_on);
            if (recv_gap != 0) take = 1'b0;
         end
      end else if (recv_gap > 0) begin
         recv_gap--;
         if (recv_gap == 0) take = 1'b1;
      end else begin
         take = 1'b1;
      end
      pop <= take;
   end

   always @(posedge clock) begin : check_proc
      enc_byte_type want;
      pixel_taken = !reset && push && (full === 1'b0);
      byte_taken = !reset && pop && (empty === 1'b0);
      if (byte_taken) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                  bytes_checked, rsp_out_byte, want.data));
            if (rsp_last_for_item !== want.last)
               report_mismatch($sformatf("byte %0d: last_for_item %b, want %b",
                  bytes_checked, rsp_last_for_item, want.last));
            if (rsp_frame_done !== want.done)
               report_mismatch($sformatf("byte %0d: frame_done %b, want %b",
                  bytes_checked, rsp_frame_done, want.done));
         end
         bytes_checked++;
         if (rsp_frame_done === 1'b1) frames_closed++;
      end
      if (pixel_taken) begin
         encode_pixel(req_pixel_value);
         pixels_sent++;
      end
      if (pixel_taken || byte_taken) stall_cycles = 0;
      else stall_cycles++;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [23:0] px;
      int          phase;
      int          count;
      int          random_items;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-pixel frames at reset sizes, gray masks the upper bytes
      pixel_queue.push_back(24'hFFFF00);
      pixel_queue.push_back(24'h0000FF);
      drain();

      set_frame(16'd4, 16'd2, 1'b0);
      pixel_queue.push_back(24'h000005);
      pixel_queue.push_back(24'h000005);
      pixel_queue.push_back(24'h000005);
      pixel_queue.push_back(24'h000007);
      pixel_queue.push_back(24'h00AB05);
      pixel_queue.push_back(24'h000005);
      pixel_queue.push_back(24'h000009);
      pixel_queue.push_back(24'h000009);
      drain();

      // color, tall frame; leave a run open and switch to gray inside it
      set_frame(16'd3, 16'hFFFF, 1'b1);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'h000000);
      pixel_queue.push_back(24'h123456);
      pixel_queue.push_back(24'h123456);
      drain();
      write_reg(REG_MODE, 32'h0);
      pixel_queue.push_back(24'h000056);
      drain();

      // zero sizes end every line and frame
      set_frame(16'd0, 16'd0, 1'b0);
      pixel_queue.push_back(24'h5A5A5A);
      pixel_queue.push_back(24'h5A5A5A);
      drain();

      set_frame(16'hFFFF, 16'd1, 1'b1);
      pixel_queue.push_back(24'hAAAAAA);
      pixel_queue.push_back(24'h555555);
      pixel_queue.push_back(24'h555555);
      drain();
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      pixel_queue.push_back(24'h0F0F0F);
      drain();

      phase = 0;
      random_items = 0;
      px = 24'($urandom());
      while (random_items < RANDOM_PIXELS) begin
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            // stall the output so the encoder backs up its input
            send_idle_on = 1'b0;
            set_frame(16'd1, 16'd1, 1'b1);
            hold_request = 60;
            count = 20;
            repeat (count) pixel_queue.push_back(24'($urandom()));
         end else if (phase == 3) begin
            set_frame(16'd300, 16'd1, 1'($urandom_range(0, 1)));
            count = 256;
            repeat (count) pixel_queue.push_back(px);
         end else begin
            if ($urandom_range(0, 5) == 0)
               set_frame(16'($urandom_range(7, 40)), 16'($urandom_range(1, 3)),
                  1'($urandom_range(0, 1)));
            else
               set_frame(16'($urandom_range(1, 6)), 16'($urandom_range(1, 3)),
                  1'($urandom_range(0, 1)));
            count = $urandom_range(12, 40);
            repeat (count) begin
               px = next_pixel(px);
               pixel_queue.push_back(px);
            end
         end
         drain();
         random_items += count;
         phase++;
      end

      $display("covered %0d pixels, %0d bytes checked, %0d frames closed, %0d register writes",
         pixels_sent, bytes_checked, frames_closed, reg_writes);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule
